// File: rtl/spab_pkg.sv
// Shared constants, codes and types of the sparse pattern adjacency builder.
package spab_pkg;

    // Largest matrix order the pattern store holds
    localparam int DEFAULT_MAX_ORDER = 64;

    // Fixed field widths
    localparam int MODE_W      = 2;
    localparam int IDX_W       = 6;
    localparam int ORDER_W     = 7;
    localparam int NB_W        = 64;
    localparam int DEG_W       = 6;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ALGORITHM = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORDER     = 1'd1;

    // Adjacency algorithms
    localparam logic ALG_SYMMETRIC = 1'b0;
    localparam logic ALG_PRODUCT   = 1'b1;

    // Configuration reset values
    localparam logic               ALGORITHM_RESET = ALG_SYMMETRIC;
    localparam logic [ORDER_W-1:0] ORDER_RESET     = 7'd64;

    // Controls of the shared adjacency unit for the row under test
    typedef struct packed {
        logic algorithm;
        logic row_hit;
        logic diag_bit;
    } adj_ctrl_t;

endpackage

// File: rtl/spab_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spab_ram #(
    parameter int WIDTH = spab_pkg::DEFAULT_MAX_ORDER,
    parameter int DEPTH = spab_pkg::DEFAULT_MAX_ORDER
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/spab_adj_unit.sv
// Shared adjacency unit: decides whether one stored row is a neighbour of the queried row.
module spab_adj_unit #(
    parameter int MAX_ORDER = spab_pkg::DEFAULT_MAX_ORDER
) (
    input  spab_pkg::adj_ctrl_t                        ctrl,
    input  logic [MAX_ORDER-1:0]                       word,
    input  logic [MAX_ORDER-1:0]                       rowbits,
    input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] qrow,
    input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0] cand,
    output logic                                       adj
);

    logic [MAX_ORDER-1:0] rj;
    logic [MAX_ORDER-1:0] withdiag;
    logic                 colbit;
    logic                 prod;
    logic                 link;

    always_comb
    begin
        rj             = ctrl.row_hit ? word : '0;
        withdiag       = rj;
        withdiag[cand] = rj[cand] | ctrl.diag_bit;
        // candidate row points back at the queried row
        colbit         = rj[qrow];
        // candidate row shares a column with the queried row
        prod           = |(withdiag & rowbits);
        if (ctrl.algorithm == spab_pkg::ALG_PRODUCT)
        begin
            link = colbit | prod;
        end
        else
        begin
            link = colbit | rowbits[cand];
        end
        adj = link && (cand != qrow);
    end

endmodule

// File: rtl/sparse_pattern_adjacency_builder_unit.sv
// Top level of the sparse pattern adjacency builder: sequencer, pattern store, result register.
// Query: the queried row is read and held, then rows 0 to n-1 are swept (n = effective order;
//   a row out of range skips the sweep); input stalled until the result is raised. One pattern
//   row is read from the RAM per sweep cycle. Load of an off-diagonal entry is a read-modify-write
//   of one row; clear, diagonal and ignored requests end in idle; finish waits on result stall.
// Reset (rst_n low, asynchronous) clears all row valid bits and the diagonal mask at once.
module sparse_pattern_adjacency_builder_unit #(
    parameter int MAX_ORDER = spab_pkg::DEFAULT_MAX_ORDER
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [spab_pkg::MODE_W-1:0]       mode,
    input  logic [spab_pkg::IDX_W-1:0]        row,
    input  logic [spab_pkg::IDX_W-1:0]        col,
    // result channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [spab_pkg::NB_W-1:0]         neighbours,
    output logic [spab_pkg::DEG_W-1:0]        degree,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spab_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [spab_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int ORDER_W = spab_pkg::ORDER_W;
    localparam int DEG_W   = spab_pkg::DEG_W;
    localparam int NB_W    = spab_pkg::NB_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_WR,
        ST_Q_ROW,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t                 state_reg,      state_next;
    logic                   algorithm_reg,  algorithm_next;
    logic [ORDER_W-1:0]     order_reg,      order_next;
    logic [MAX_ORDER-1:0]   row_valid_reg,  row_valid_next;
    logic [MAX_ORDER-1:0]   diag_reg,       diag_next;
    logic                   row_hit_reg,    row_hit_next;
    logic [AW-1:0]          qrow_reg,       qrow_next;
    logic [AW-1:0]          qcol_reg,       qcol_next;
    logic [AW-1:0]          jd_reg,         jd_next;
    logic [MAX_ORDER-1:0]   rowbits_reg,    rowbits_next;
    logic [MAX_ORDER-1:0]   nb_reg,         nb_next;
    logic [DEG_W-1:0]       deg_reg,        deg_next;
    logic                   result_valid_reg, result_valid_next;
    logic [NB_W-1:0]        neighbours_reg, neighbours_next;
    logic [DEG_W-1:0]       degree_reg,     degree_next;

    logic [ORDER_W-1:0]     n_eff;
    logic [MAX_ORDER-1:0]   vmask;
    logic                   row_in_range;
    logic                   col_in_range;
    logic                   out_free;
    logic [MAX_ORDER-1:0]   stored_word;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [MAX_ORDER-1:0]   ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [MAX_ORDER-1:0]   ram_rdata;

    spab_pkg::adj_ctrl_t    adj_ctrl;
    logic                   adj_bit;

    // Off-diagonal pattern, one row per word
    spab_ram #(
        .WIDTH (MAX_ORDER),
        .DEPTH (MAX_ORDER)
    ) u_pattern (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // One candidate row per sweep cycle goes through the shared unit
    assign adj_ctrl.algorithm = algorithm_reg;
    assign adj_ctrl.row_hit   = row_hit_reg;
    assign adj_ctrl.diag_bit  = diag_reg[jd_reg];

    spab_adj_unit #(
        .MAX_ORDER (MAX_ORDER)
    ) u_adj (
        .ctrl    (adj_ctrl),
        .word    (ram_rdata),
        .rowbits (rowbits_reg),
        .qrow    (qrow_reg),
        .cand    (jd_reg),
        .adj     (adj_bit)
    );

    // Effective order and the column mask it implies
    always_comb
    begin
        n_eff = (order_reg > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_reg;
        for (int k = 0; k < MAX_ORDER; k++)
        begin
            vmask[k] = (ORDER_W'(k) < n_eff);
        end
    end

    assign row_in_range = (ORDER_W'(row) < n_eff);
    assign col_in_range = (ORDER_W'(col) < n_eff);
    assign out_free     = !result_valid_reg || !result_stall;
    // Rows never written since the last clear read as empty
    assign stored_word  = row_hit_reg ? ram_rdata : '0;

    assign item_stall   = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign neighbours   = neighbours_reg;
    assign degree       = degree_reg;

    always_comb
    begin
        state_next        = state_reg;
        algorithm_next    = algorithm_reg;
        order_next        = order_reg;
        row_valid_next    = row_valid_reg;
        diag_next         = diag_reg;
        row_hit_next      = row_hit_reg;
        qrow_next         = qrow_reg;
        qcol_next         = qcol_reg;
        jd_next           = jd_reg;
        rowbits_next      = rowbits_reg;
        nb_next           = nb_reg;
        deg_next          = deg_reg;
        result_valid_next = result_valid_reg;
        neighbours_next   = neighbours_reg;
        degree_next       = degree_reg;

        ram_we    = 1'b0;
        ram_waddr = qrow_reg;
        ram_wdata = stored_word | (MAX_ORDER'(1) << qcol_reg);
        ram_re    = 1'b0;
        ram_raddr = row[AW-1:0];

        // Drop the result once it is taken
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                spab_pkg::CFG_ALGORITHM: algorithm_next = cfg_data[0];
                spab_pkg::CFG_ORDER:     order_next     = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (mode)
                        spab_pkg::MODE_CLEAR:
                        begin
                            row_valid_next = '0;
                            diag_next      = '0;
                        end
                        spab_pkg::MODE_LOAD:
                        begin
                            if (row_in_range && col_in_range)
                            begin
                                if (row == col)
                                begin
                                    diag_next[row[AW-1:0]] = 1'b1;
                                end
                                else
                                begin
                                    // Fetch the row, merge the column bit next cycle
                                    ram_re     = 1'b1;
                                    ram_raddr  = row[AW-1:0];
                                    qrow_next  = row[AW-1:0];
                                    qcol_next  = col[AW-1:0];
                                    state_next = ST_LOAD_WR;
                                end
                            end
                        end
                        spab_pkg::MODE_QUERY:
                        begin
                            nb_next   = '0;
                            deg_next  = '0;
                            qrow_next = row[AW-1:0];
                            if (row_in_range)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = row[AW-1:0];
                                state_next = ST_Q_ROW;
                            end
                            else
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        default: ;
                    endcase
                    if (ram_re)
                    begin
                        row_hit_next = row_valid_reg[ram_raddr];
                    end
                end
            end
            ST_LOAD_WR:
            begin
                ram_we                   = 1'b1;
                row_valid_next[qrow_reg] = 1'b1;
                state_next               = ST_IDLE;
            end
            ST_Q_ROW:
            begin
                // Hold the queried row, start the sweep at row zero
                rowbits_next = stored_word & vmask;
                ram_re       = 1'b1;
                ram_raddr    = '0;
                row_hit_next = row_valid_reg[0];
                jd_next      = '0;
                state_next   = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                nb_next[jd_reg] = adj_bit;
                deg_next        = deg_reg + DEG_W'(adj_bit);
                if ((ORDER_W'(jd_reg) + ORDER_W'(1)) == n_eff)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    // Advance to the next stored row
                    ram_re       = 1'b1;
                    ram_raddr    = jd_reg + AW'(1);
                    row_hit_next = row_valid_reg[ram_raddr];
                    jd_next      = jd_reg + AW'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    neighbours_next   = NB_W'(nb_reg);
                    degree_next       = deg_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            algorithm_reg    <= spab_pkg::ALGORITHM_RESET;
            order_reg        <= spab_pkg::ORDER_RESET;
            row_valid_reg    <= '0;
            diag_reg         <= '0;
            row_hit_reg      <= 1'b0;
            qrow_reg         <= '0;
            qcol_reg         <= '0;
            jd_reg           <= '0;
            rowbits_reg      <= '0;
            nb_reg           <= '0;
            deg_reg          <= '0;
            result_valid_reg <= 1'b0;
            neighbours_reg   <= '0;
            degree_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            algorithm_reg    <= algorithm_next;
            order_reg        <= order_next;
            row_valid_reg    <= row_valid_next;
            diag_reg         <= diag_next;
            row_hit_reg      <= row_hit_next;
            qrow_reg         <= qrow_next;
            qcol_reg         <= qcol_next;
            jd_reg           <= jd_next;
            rowbits_reg      <= rowbits_next;
            nb_reg           <= nb_next;
            deg_reg          <= deg_next;
            result_valid_reg <= result_valid_next;
            neighbours_reg   <= neighbours_next;
            degree_reg       <= degree_next;
        end
    end

    // A result appears only out of the finish step
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish step");

    // Degree is the population count of the mask
    a_degree_popcount: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($countones(neighbours) == int'(degree)))
        else $error("degree does not match neighbour mask");

    // The queried vertex is never its own neighbour
    a_no_self_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (nb_reg[qrow_reg] == 1'b0))
        else $error("queried row marked as its own neighbour");

    // The pattern RAM is never read and written in the same cycle
    a_ram_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("pattern RAM read and write collide");

endmodule
